// ===== hdl/rlss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlss_pkg
// shared types, codes and defaults of the run-length sequence store
// ----------------------------------------------------------------------------
package rlss_pkg;

    // default sizing, handed down from the top level
    localparam int MAX_RUNS_DEF   = 64;
    localparam int COUNT_BITS_DEF = 16;

    // fixed total-length field width and its maximum
    localparam int TOTAL_W = 16;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         letter_in;
        logic [TOTAL_W-1:0] position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         letter_out;
        logic [TOTAL_W-1:0] total_length;
    } t_out_item;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_MERGE,
        S_SHIFT,
        S_FINISH
    } t_state;

    // datapath commands
    typedef enum logic [2:0] {
        DP_IDLE,
        DP_START,
        DP_APPEND,
        DP_SCAN,
        DP_MERGE,
        DP_SHIFT,
        DP_LOAD
    } t_dp_cmd;

    // datapath status towards the controller
    typedef struct packed {
        logic in_idx_err;
        logic hit;
        logic run_empties;
        logic shift_done;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== hdl/rlss_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlss_stream_if
// valid/ready channel carrying one item per handshake
// ----------------------------------------------------------------------------
interface rlss_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/rlss_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlss_ctrl
// sequencer: accepts one item, steps the datapath, hands the result out
// ----------------------------------------------------------------------------
module rlss_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic [1:0]         i_in_opcode,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rlss_pkg::t_dp_cmd       o_cmd,
    input  wire rlss_pkg::t_dp_stat i_stat
);
    import rlss_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_op, n_op;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_opcode)
                        OP_APPEND: n_state = S_APPEND;
                        OP_GET:    n_state = i_stat.in_idx_err ? S_FINISH : S_SCAN;
                        OP_REMOVE: n_state = i_stat.in_idx_err ? S_FINISH : S_SCAN;
                        default:   n_state = S_FINISH;
                    endcase
                end
            end
            S_APPEND: n_state = S_FINISH;
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_state = (r_op == OP_REMOVE && i_stat.run_empties) ? S_MERGE : S_FINISH;
                end
            end
            S_MERGE: n_state = S_SHIFT;
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = DP_IDLE;
        n_op        = r_op;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = DP_START;
                    n_op  = i_in_opcode;
                end
            end
            S_APPEND: o_cmd = DP_APPEND;
            S_SCAN:   o_cmd = DP_SCAN;
            S_MERGE:  o_cmd = DP_MERGE;
            S_SHIFT:  o_cmd = DP_SHIFT;
            S_FINISH: begin
                if (out_free) begin
                    o_cmd       = DP_LOAD;
                    n_out_valid = 1'b1;
                end
            end
            default: o_cmd = DP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FINISH)
        else $error("result raised outside finish");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finish did not load the result");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state != S_IDLE)
        else $error("accepted item left no work");

endmodule
`default_nettype wire

// ===== hdl/rlss_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlss_dpath
// run table memory, counters, position scan, merge and shift datapath
// ----------------------------------------------------------------------------
module rlss_dpath #(
    parameter int MAX_RUNS   = rlss_pkg::MAX_RUNS_DEF,
    parameter int COUNT_BITS = rlss_pkg::COUNT_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire rlss_pkg::t_in_item  i_in_data,
    input  wire rlss_pkg::t_dp_cmd   i_cmd,
    output rlss_pkg::t_dp_stat       o_stat,
    output rlss_pkg::t_out_item      o_out_data
);
    import rlss_pkg::*;

    localparam int RUN_W  = $clog2(MAX_RUNS);
    localparam int USED_W = $clog2(MAX_RUNS + 1);
    localparam int SUM_W  = ((COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // run table
    logic [7:0]            mem_letter [MAX_RUNS];
    logic [COUNT_BITS-1:0] mem_len    [MAX_RUNS];
    logic [7:0]            r_rd_letter;
    logic [COUNT_BITS-1:0] r_rd_len;
    logic [RUN_W-1:0]      rd_addr, wr_addr;
    logic                  wr_en;
    logic [7:0]            wr_letter;
    logic [COUNT_BITS-1:0] wr_len;

    // state and working registers
    logic [USED_W-1:0]     r_runs_used, n_runs_used;
    logic [TOTAL_W-1:0]    r_char_total, n_char_total;
    logic [1:0]            r_op, n_op;
    logic [7:0]            r_letter_in, n_letter_in;
    logic [TOTAL_W-1:0]    r_pos, n_pos;
    logic [RUN_W-1:0]      r_k, n_k;
    logic [TOTAL_W-1:0]    r_acc, n_acc;
    logic [7:0]            r_prev_letter, n_prev_letter;
    logic [COUNT_BITS-1:0] r_prev_len, n_prev_len;
    logic [USED_W-1:0]     r_src, n_src;
    logic [USED_W-1:0]     r_wr, n_wr;
    logic [USED_W-1:0]     r_end, n_end;
    logic                  r_dv, n_dv;
    logic [1:0]            r_status, n_status;
    logic [7:0]            r_letter_out, n_letter_out;
    t_out_item             r_out, n_out;

    // derived values
    logic [SUM_W-1:0]      scan_sum;
    logic                  scan_hit;
    logic [RUN_W-1:0]      k_next;
    logic [USED_W-1:0]     k_plus1;
    logic [COUNT_BITS:0]   merge_sum;
    logic                  do_merge;
    logic [RUN_W-1:0]      last_idx;
    logic                  can_rd;

    assign scan_sum  = SUM_W'(r_acc) + SUM_W'(r_rd_len);
    assign scan_hit  = SUM_W'(r_pos) < scan_sum;
    assign k_next    = (r_k == RUN_W'(MAX_RUNS - 1)) ? '0 : r_k + 1'b1;
    assign k_plus1   = USED_W'(r_k) + 1'b1;
    assign merge_sum = {1'b0, r_prev_len} + {1'b0, r_rd_len};
    assign do_merge  = (r_k != '0) && (k_plus1 < r_runs_used)
                       && (r_prev_letter == r_rd_letter) && !merge_sum[COUNT_BITS];
    assign last_idx  = (r_runs_used == '0) ? '0 : RUN_W'(r_runs_used - 1'b1);
    assign can_rd    = r_src < r_end;

    assign o_stat.in_idx_err  = i_in_data.position >= r_char_total;
    assign o_stat.hit         = scan_hit;
    assign o_stat.run_empties = r_rd_len == COUNT_BITS'(1);
    assign o_stat.shift_done  = !r_dv && !can_rd;
    assign o_out_data         = r_out;

    always_comb begin
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_letter     = r_rd_letter;
        wr_len        = r_rd_len;
        n_runs_used   = r_runs_used;
        n_char_total  = r_char_total;
        n_op          = r_op;
        n_letter_in   = r_letter_in;
        n_pos         = r_pos;
        n_k           = r_k;
        n_acc         = r_acc;
        n_prev_letter = r_prev_letter;
        n_prev_len    = r_prev_len;
        n_src         = r_src;
        n_wr          = r_wr;
        n_end         = r_end;
        n_dv          = r_dv;
        n_status      = r_status;
        n_letter_out  = r_letter_out;
        n_out         = r_out;
        case (i_cmd)
            DP_START: begin
                n_op         = i_in_data.opcode;
                n_letter_in  = i_in_data.letter_in;
                n_pos        = i_in_data.position;
                n_k          = '0;
                n_acc        = '0;
                n_letter_out = '0;
                n_status     = ((i_in_data.opcode == OP_GET || i_in_data.opcode == OP_REMOVE)
                                && o_stat.in_idx_err) ? ST_INDEX : ST_OK;
                // append wants the last run, a scan starts at run zero
                rd_addr      = (i_in_data.opcode == OP_APPEND) ? last_idx : '0;
            end
            DP_APPEND: begin
                if (r_char_total == TOTAL_MAX) begin
                    n_status = ST_FULL;
                end else if (r_runs_used != '0 && r_rd_letter == r_letter_in) begin
                    if (r_rd_len == COUNT_MAX) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en        = 1'b1;
                        wr_addr      = last_idx;
                        wr_letter    = r_letter_in;
                        wr_len       = r_rd_len + 1'b1;
                        n_char_total = r_char_total + 1'b1;
                    end
                end else if (r_runs_used == USED_W'(MAX_RUNS)) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en        = 1'b1;
                    wr_addr      = RUN_W'(r_runs_used);
                    wr_letter    = r_letter_in;
                    wr_len       = COUNT_BITS'(1);
                    n_runs_used  = r_runs_used + 1'b1;
                    n_char_total = r_char_total + 1'b1;
                end
            end
            DP_SCAN: begin
                // next run is fetched either way: a remove needs it for the merge
                rd_addr = k_next;
                if (scan_hit) begin
                    if (r_op == OP_GET) begin
                        n_letter_out = r_rd_letter;
                    end else begin
                        wr_en        = 1'b1;
                        wr_addr      = r_k;
                        wr_len       = r_rd_len - 1'b1;
                        n_char_total = r_char_total - 1'b1;
                    end
                end else begin
                    n_acc         = scan_sum[TOTAL_W-1:0];
                    n_prev_letter = r_rd_letter;
                    n_prev_len    = r_rd_len;
                    n_k           = k_next;
                end
            end
            DP_MERGE: begin
                n_wr  = USED_W'(r_k);
                n_end = r_runs_used;
                n_dv  = 1'b0;
                if (do_merge) begin
                    wr_en       = 1'b1;
                    wr_addr     = r_k - 1'b1;
                    wr_letter   = r_prev_letter;
                    wr_len      = merge_sum[COUNT_BITS-1:0];
                    n_src       = k_plus1 + 1'b1;
                    n_runs_used = r_runs_used - USED_W'(2);
                end else begin
                    n_src       = k_plus1;
                    n_runs_used = r_runs_used - 1'b1;
                end
            end
            DP_SHIFT: begin
                // read one run ahead, write the one fetched last cycle
                rd_addr = can_rd ? RUN_W'(r_src) : '0;
                n_dv    = can_rd;
                if (can_rd) begin
                    n_src = r_src + 1'b1;
                end
                if (r_dv) begin
                    wr_en   = 1'b1;
                    wr_addr = RUN_W'(r_wr);
                    n_wr    = r_wr + 1'b1;
                end
            end
            DP_LOAD: begin
                n_out.status       = r_status;
                n_out.letter_out   = r_letter_out;
                n_out.total_length = r_char_total;
            end
            default: begin
                n_out = r_out;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_letter[wr_addr] <= wr_letter;
            mem_len[wr_addr]    <= wr_len;
        end
        r_rd_letter <= mem_letter[rd_addr];
        r_rd_len    <= mem_len[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_runs_used  <= '0;
            r_char_total <= '0;
            r_dv         <= 1'b0;
        end else begin
            r_runs_used  <= n_runs_used;
            r_char_total <= n_char_total;
            r_dv         <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_letter_in   <= n_letter_in;
        r_pos         <= n_pos;
        r_k           <= n_k;
        r_acc         <= n_acc;
        r_prev_letter <= n_prev_letter;
        r_prev_len    <= n_prev_len;
        r_src         <= n_src;
        r_wr          <= n_wr;
        r_end         <= n_end;
        r_status      <= n_status;
        r_letter_out  <= n_letter_out;
        r_out         <= n_out;
    end

    a_runs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_runs_used <= USED_W'(MAX_RUNS))
        else $error("run count beyond table depth");

    // the total drops in the cycle before the run count does on a remove that empties a run
    a_empty_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd != DP_MERGE) |-> ((r_runs_used == '0) == (r_char_total == '0)))
        else $error("run count and total disagree on empty");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_SCAN) |-> (USED_W'(r_k) < r_runs_used))
        else $error("scan ran past the last run");

    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_SHIFT && r_dv) |-> (r_wr < r_src))
        else $error("shift write overtook its read");

endmodule
`default_nettype wire

// ===== hdl/run_length_sequence_store_top.sv =====
`default_nettype none
// append reads the last run and extends it, writes a new run after it, or reports full;
//   get and remove scan from run zero to the run holding the position (one run a cycle)
// remove: a run that empties goes, merged with its neighbours if they match and fit,
//   and the runs after it move down one at a time; a stalled result waits in finish
// one item at a time: next item is taken the cycle after its result is loaded
// reset clears run count and total length; run table is not cleared
// ----------------------------------------------------------------------------
// run_length_sequence_store_top
// character sequence held as a bounded table of (letter, count) runs
// ----------------------------------------------------------------------------
module run_length_sequence_store_top #(
    parameter int MAX_RUNS   = rlss_pkg::MAX_RUNS_DEF,
    parameter int COUNT_BITS = rlss_pkg::COUNT_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rlss_stream_if.sink   i_cmd,
    rlss_stream_if.source o_res
);
    import rlss_pkg::*;

    // command and status between the sequencer and the datapath
    t_dp_cmd   dp_cmd;
    t_dp_stat  dp_stat;

    // handshake wires of the two channels
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    assign i_cmd.ready = in_ready;
    assign o_res.valid = out_valid;
    assign o_res.data  = out_data;

    // sequencer: owns the state machine and the result valid flag
    rlss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_in_opcode (i_cmd.data.opcode),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    // datapath: run table memory, run count, total, scan and shift logic
    rlss_dpath #(
        .MAX_RUNS   (MAX_RUNS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_cmd.data),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_out_data (out_data)
    );

endmodule
`default_nettype wire
